// ----- rtl/range_add_range_sum_tree_core_defines.svh -----
// Assertion macros for the range add / range sum core.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef RANGE_ADD_RANGE_SUM_TREE_CORE_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_TREE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RASUM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasum: same-cycle check failed");
`define RASUM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasum: next-cycle check failed");
`else
`define RASUM_ASSERT_IMP(lbl, ante, cons)
`define RASUM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/rasum_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the microcode ROM of the range add / range sum core.
// No dependencies; rasum_seq, rasum_dp and the top level refer to it by scoped names.
package rasum_pkg;

    localparam int MAX_ELEMS = 1024;
    localparam int FIELD_W   = 11;
    localparam int WORD_W    = 64;
    localparam int ADDR_W    = $clog2(MAX_ELEMS);
    // Tree positions climb up to twice the array size during an update walk
    localparam int POS_W     = $clog2(MAX_ELEMS) + 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int UPC_W     = 4;

    localparam logic [FIELD_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_ADD   = 1'b1;

    typedef enum logic [0:0] {
        REG_SIZE_IN_USE = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] left;
        logic [FIELD_W-1:0] right;
        logic [WORD_W-1:0]  amount;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] range_total;
        logic              range_error;
    } rsp_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_WAIT_REQ,
        JMP_DISPATCH,
        JMP_LOOP,
        JMP_WAIT_RSP
    } jmp_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_LEFT,
        POS_RIGHT,
        POS_RIGHT1,
        POS_LEFTM1
    } pos_op_t;

    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_UP,
        WALK_DOWN
    } walk_t;

    typedef enum logic [1:0] {
        MUL_AMT_LEFTM1,
        MUL_AMT_RIGHT,
        MUL_ACC_RIGHT,
        MUL_ACC_LEFTM1
    } mul_op_t;

    typedef enum logic [2:0] {
        VAL_HOLD,
        VAL_D_AMT,
        VAL_D_NEG,
        VAL_W_MUL,
        VAL_W_NEG
    } val_op_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_FIRST,
        RES_FINAL
    } res_op_t;

    typedef struct packed {
        jmp_t    jmp;
        upc_t    target;
        pos_op_t pos_op;
        walk_t   walk;
        mul_op_t mul_op;
        val_op_t val_op;
        res_op_t res_op;
        logic    acc_clr;
        logic    emit;
    } ucode_t;

    typedef struct packed {
        logic item_ok;
        logic item_add;
        logic walk_more;
        logic clearing;
    } dp_status_t;

    // Program addresses
    localparam upc_t UA_IDLE      = 4'd0;
    localparam upc_t UA_DECODE    = 4'd1;
    localparam upc_t UA_ADD_MUL1  = 4'd2;
    localparam upc_t UA_ADD_SETW1 = 4'd3;
    localparam upc_t UA_ADD_WALK1 = 4'd4;
    localparam upc_t UA_ADD_MUL2  = 4'd5;
    localparam upc_t UA_ADD_SETW2 = 4'd6;
    localparam upc_t UA_ADD_WALK2 = 4'd7;
    localparam upc_t UA_Q_START   = 4'd8;
    localparam upc_t UA_Q_WALK1   = 4'd9;
    localparam upc_t UA_Q_MUL1    = 4'd10;
    localparam upc_t UA_Q_SAVE1   = 4'd11;
    localparam upc_t UA_Q_WALK2   = 4'd12;
    localparam upc_t UA_Q_MUL2    = 4'd13;
    localparam upc_t UA_Q_FIN     = 4'd14;
    localparam upc_t UA_EMIT      = 4'd15;

    localparam ucode_t UCODE_NOP = '{
        jmp:     JMP_NEXT,
        target:  UA_IDLE,
        pos_op:  POS_HOLD,
        walk:    WALK_NONE,
        mul_op:  MUL_AMT_RIGHT,
        val_op:  VAL_HOLD,
        res_op:  RES_HOLD,
        acc_clr: 1'b0,
        emit:    1'b0
    };

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = UCODE_NOP;
        case (addr)
            UA_IDLE:      w.jmp = JMP_WAIT_REQ;
            UA_DECODE:    w.jmp = JMP_DISPATCH;
            UA_ADD_MUL1:
            begin
                w.pos_op = POS_LEFT;
                w.mul_op = MUL_AMT_LEFTM1;
                w.val_op = VAL_D_AMT;
            end
            UA_ADD_SETW1: w.val_op = VAL_W_MUL;
            UA_ADD_WALK1:
            begin
                w.walk   = WALK_UP;
                w.jmp    = JMP_LOOP;
                w.target = UA_ADD_MUL2;
            end
            UA_ADD_MUL2:
            begin
                w.pos_op = POS_RIGHT1;
                w.mul_op = MUL_AMT_RIGHT;
                w.val_op = VAL_D_NEG;
            end
            UA_ADD_SETW2: w.val_op = VAL_W_NEG;
            UA_ADD_WALK2:
            begin
                w.walk   = WALK_UP;
                w.jmp    = JMP_LOOP;
                w.target = UA_IDLE;
            end
            UA_Q_START:
            begin
                w.pos_op  = POS_RIGHT;
                w.acc_clr = 1'b1;
            end
            UA_Q_WALK1:
            begin
                w.walk   = WALK_DOWN;
                w.jmp    = JMP_LOOP;
                w.target = UA_Q_MUL1;
            end
            UA_Q_MUL1:    w.mul_op = MUL_ACC_RIGHT;
            UA_Q_SAVE1:
            begin
                w.res_op  = RES_FIRST;
                w.pos_op  = POS_LEFTM1;
                w.acc_clr = 1'b1;
            end
            UA_Q_WALK2:
            begin
                w.walk   = WALK_DOWN;
                w.jmp    = JMP_LOOP;
                w.target = UA_Q_MUL2;
            end
            UA_Q_MUL2:    w.mul_op = MUL_ACC_LEFTM1;
            UA_Q_FIN:     w.res_op = RES_FINAL;
            UA_EMIT:
            begin
                w.jmp    = JMP_WAIT_RSP;
                w.target = UA_IDLE;
                w.emit   = 1'b1;
            end
            default:
            begin
                w.jmp    = JMP_GOTO;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/rasum_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module rasum_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rasum_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on rasum_pkg for the control word, program addresses and status struct.
module rasum_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rasum_pkg::dp_status_t status,
    input  logic                  req_accept,
    input  logic                  rsp_free,
    output rasum_pkg::ucode_t     ctrl,
    output logic                  ready
);

    rasum_pkg::upc_t upc_reg;
    rasum_pkg::upc_t upc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= rasum_pkg::UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        ctrl     = rasum_pkg::ucode_rom(upc_reg);
        ready    = (upc_reg == rasum_pkg::UA_IDLE) && !status.clearing;
        upc_next = upc_reg + rasum_pkg::UPC_W'(1);
        case (ctrl.jmp)
            rasum_pkg::JMP_NEXT:     upc_next = upc_reg + rasum_pkg::UPC_W'(1);
            rasum_pkg::JMP_GOTO:     upc_next = ctrl.target;
            rasum_pkg::JMP_WAIT_REQ:
            begin
                upc_next = req_accept ? rasum_pkg::UA_DECODE : upc_reg;
            end
            rasum_pkg::JMP_DISPATCH:
            begin
                // malformed add: drop; malformed query: straight to the error word
                if (status.item_add)
                begin
                    upc_next = status.item_ok ? rasum_pkg::UA_ADD_MUL1 : rasum_pkg::UA_IDLE;
                end
                else
                begin
                    upc_next = status.item_ok ? rasum_pkg::UA_Q_START : rasum_pkg::UA_EMIT;
                end
            end
            rasum_pkg::JMP_LOOP:     upc_next = status.walk_more ? upc_reg : ctrl.target;
            rasum_pkg::JMP_WAIT_RSP: upc_next = rsp_free ? ctrl.target : upc_reg;
            default:                 upc_next = rasum_pkg::UA_IDLE;
        endcase
    end

endmodule

// ----- rtl/rasum_dp.sv -----
`timescale 1ns / 1ps
// Datapath: item register, tree walkers, shared multiplier, accumulators and both tree RAMs.
// Depends on rasum_pkg and rasum_ram; driven by the control word from rasum_seq.
module rasum_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rasum_pkg::ucode_t                 ctrl,
    input  logic                              req_accept,
    input  rasum_pkg::req_t                   req,
    input  logic [rasum_pkg::FIELD_W-1:0]     size,
    output rasum_pkg::dp_status_t             status,
    output rasum_pkg::rsp_t                   result
);

    rasum_pkg::req_t                   item_reg;
    logic [rasum_pkg::POS_W-1:0]       pos_reg;
    logic [rasum_pkg::POS_W-1:0]       pos_next;
    logic [rasum_pkg::POS_W-1:0]       wa_reg;
    logic [rasum_pkg::POS_W-1:0]       wa_next;
    logic                              pend_reg;
    logic                              pend_next;
    logic                              clr_reg;
    logic [rasum_pkg::ADDR_W-1:0]      clr_cnt_reg;
    logic [rasum_pkg::WORD_W-1:0]      val_d_reg;
    logic [rasum_pkg::WORD_W-1:0]      val_d_next;
    logic [rasum_pkg::WORD_W-1:0]      val_w_reg;
    logic [rasum_pkg::WORD_W-1:0]      val_w_next;
    logic [rasum_pkg::WORD_W-1:0]      mul_reg;
    logic [rasum_pkg::WORD_W-1:0]      mul_next;
    logic [rasum_pkg::WORD_W-1:0]      acc_d_reg;
    logic [rasum_pkg::WORD_W-1:0]      acc_d_next;
    logic [rasum_pkg::WORD_W-1:0]      acc_w_reg;
    logic [rasum_pkg::WORD_W-1:0]      acc_w_next;
    logic [rasum_pkg::WORD_W-1:0]      res_reg;
    logic [rasum_pkg::WORD_W-1:0]      res_next;

    logic [rasum_pkg::POS_W-1:0]       lowbit;
    logic                              pos_in_tree;
    logic                              item_ok;
    logic [rasum_pkg::FIELD_W-1:0]     left_m1;
    logic [rasum_pkg::WORD_W-1:0]      mul_a;
    logic [rasum_pkg::FIELD_W-1:0]     mul_b;

    logic                              we;
    logic [rasum_pkg::ADDR_W-1:0]      waddr;
    logic [rasum_pkg::ADDR_W-1:0]      raddr;
    logic [rasum_pkg::WORD_W-1:0]      diff_wdata;
    logic [rasum_pkg::WORD_W-1:0]      wt_wdata;
    logic [rasum_pkg::WORD_W-1:0]      diff_rdata;
    logic [rasum_pkg::WORD_W-1:0]      wt_rdata;

    rasum_ram #(
        .WIDTH (rasum_pkg::WORD_W),
        .DEPTH (rasum_pkg::MAX_ELEMS)
    ) u_diff_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (diff_wdata),
        .raddr (raddr),
        .rdata (diff_rdata)
    );

    rasum_ram #(
        .WIDTH (rasum_pkg::WORD_W),
        .DEPTH (rasum_pkg::MAX_ELEMS)
    ) u_wt_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wt_wdata),
        .raddr (raddr),
        .rdata (wt_rdata)
    );

    always_comb
    begin
        lowbit      = pos_reg & (~pos_reg + rasum_pkg::POS_W'(1));
        pos_in_tree = (pos_reg != '0)
                      && (32'(pos_reg) <= 32'(rasum_pkg::MAX_ELEMS));
        left_m1     = item_reg.left - rasum_pkg::FIELD_W'(1);
        item_ok     = (item_reg.left != '0)
                      && (item_reg.left <= item_reg.right)
                      && (item_reg.right <= size)
                      && (32'(item_reg.right) <= 32'(rasum_pkg::MAX_ELEMS));

        status.item_ok  = item_ok;
        status.item_add = (item_reg.func == rasum_pkg::FUNC_ADD);
        status.clearing = clr_reg;
        case (ctrl.walk)
            rasum_pkg::WALK_UP:   status.walk_more = pos_in_tree;
            rasum_pkg::WALK_DOWN: status.walk_more = (pos_reg != '0);
            default:              status.walk_more = 1'b0;
        endcase

        result.range_total = item_ok ? res_reg : '0;
        result.range_error = !item_ok;
    end

    // Walker: each cycle issues a read at pos and retires the read issued the cycle before
    always_comb
    begin
        pos_next  = pos_reg;
        wa_next   = wa_reg;
        pend_next = 1'b0;
        case (ctrl.pos_op)
            rasum_pkg::POS_LEFT:   pos_next = rasum_pkg::POS_W'(item_reg.left);
            rasum_pkg::POS_RIGHT:  pos_next = rasum_pkg::POS_W'(item_reg.right);
            rasum_pkg::POS_RIGHT1:
            begin
                pos_next = rasum_pkg::POS_W'(item_reg.right) + rasum_pkg::POS_W'(1);
            end
            rasum_pkg::POS_LEFTM1: pos_next = rasum_pkg::POS_W'(left_m1);
            default:               pos_next = pos_reg;
        endcase
        case (ctrl.walk)
            rasum_pkg::WALK_UP:
            begin
                if (pos_in_tree)
                begin
                    pos_next  = pos_reg + lowbit;
                    wa_next   = pos_reg;
                    pend_next = 1'b1;
                end
            end
            rasum_pkg::WALK_DOWN:
            begin
                if (pos_reg != '0)
                begin
                    pos_next  = pos_reg - lowbit;
                    pend_next = 1'b1;
                end
            end
            default: ;
        endcase

        raddr = rasum_pkg::ADDR_W'(pos_reg - rasum_pkg::POS_W'(1));
        if (clr_reg)
        begin
            we         = 1'b1;
            waddr      = clr_cnt_reg;
            diff_wdata = '0;
            wt_wdata   = '0;
        end
        else
        begin
            we         = (ctrl.walk == rasum_pkg::WALK_UP) && pend_reg;
            waddr      = rasum_pkg::ADDR_W'(wa_reg - rasum_pkg::POS_W'(1));
            diff_wdata = diff_rdata + val_d_reg;
            wt_wdata   = wt_rdata + val_w_reg;
        end
    end

    always_comb
    begin
        acc_d_next = acc_d_reg;
        acc_w_next = acc_w_reg;
        if (ctrl.acc_clr)
        begin
            acc_d_next = '0;
            acc_w_next = '0;
        end
        else if ((ctrl.walk == rasum_pkg::WALK_DOWN) && pend_reg)
        begin
            acc_d_next = acc_d_reg + diff_rdata;
            acc_w_next = acc_w_reg + wt_rdata;
        end

        case (ctrl.mul_op)
            rasum_pkg::MUL_AMT_LEFTM1:
            begin
                mul_a = item_reg.amount;
                mul_b = left_m1;
            end
            rasum_pkg::MUL_AMT_RIGHT:
            begin
                mul_a = item_reg.amount;
                mul_b = item_reg.right;
            end
            rasum_pkg::MUL_ACC_RIGHT:
            begin
                mul_a = acc_d_reg;
                mul_b = item_reg.right;
            end
            rasum_pkg::MUL_ACC_LEFTM1:
            begin
                mul_a = acc_d_reg;
                mul_b = left_m1;
            end
            default:
            begin
                mul_a = item_reg.amount;
                mul_b = item_reg.right;
            end
        endcase
        mul_next = mul_a * rasum_pkg::WORD_W'(mul_b);

        val_d_next = val_d_reg;
        val_w_next = val_w_reg;
        case (ctrl.val_op)
            rasum_pkg::VAL_D_AMT: val_d_next = item_reg.amount;
            rasum_pkg::VAL_D_NEG: val_d_next = rasum_pkg::WORD_W'(0) - item_reg.amount;
            rasum_pkg::VAL_W_MUL: val_w_next = mul_reg;
            rasum_pkg::VAL_W_NEG: val_w_next = rasum_pkg::WORD_W'(0) - mul_reg;
            default: ;
        endcase

        // P(x) = x * D(x) - W(x); answer is P(right) - P(left - 1)
        case (ctrl.res_op)
            rasum_pkg::RES_FIRST: res_next = mul_reg - acc_w_reg;
            rasum_pkg::RES_FINAL: res_next = res_reg - mul_reg + acc_w_reg;
            default:              res_next = res_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + rasum_pkg::ADDR_W'(1);
                if (clr_cnt_reg == rasum_pkg::ADDR_W'(rasum_pkg::MAX_ELEMS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            item_reg <= req;
        end
        pos_reg   <= pos_next;
        wa_reg    <= wa_next;
        val_d_reg <= val_d_next;
        val_w_reg <= val_w_next;
        mul_reg   <= mul_next;
        acc_d_reg <= acc_d_next;
        acc_w_reg <= acc_w_next;
        res_reg   <= res_next;
    end

endmodule

// ----- rtl/range_add_range_sum_tree_core.sv -----
`timescale 1ns / 1ps
// Range add / range sum core over two Fenwick trees of 64-bit words.
// Usage:
//   req channel (req_valid/req_ready/req) takes one word per item: func 1 adds
//   amount to every element of left..right, func 0 asks for the sum of left..right.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one word per query, none per add;
//   a malformed query returns range_error = 1 and a zero total, a malformed add is dropped.
//   The APB port holds size_in_use at address 0; write it only while the core is idle.
// Walks: each of the two walks of an item visits at most log2(MAX_ELEMS) + 1 tree nodes,
//   11 at 1024 elements. Both trees share one RAM read address and are read once per node;
//   an add decodes, then for each end multiplies, sets the weight and walks up; a query
//   decodes, then for each end walks down and multiplies, and finally emits the answer.
// Reset: both trees are zeroed by a clearing pass over all 1024 entries (one entry per cycle);
//   req_ready stays low until it ends, configuration writes are taken throughout.
// Stall: the result sits in an output register; a new item is accepted while it waits,
//   and the core holds on its final step only if the next answer is ready first.
// Depends on rasum_pkg, rasum_seq, rasum_dp, rasum_ram and the defines header.
`include "range_add_range_sum_tree_core_defines.svh"
module range_add_range_sum_tree_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rasum_pkg::PADDR_W-1:0]   paddr,
    input  logic [rasum_pkg::PDATA_W-1:0]   pwdata,
    output logic [rasum_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  rasum_pkg::req_t                 req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output rasum_pkg::rsp_t                 rsp
);

    logic [rasum_pkg::FIELD_W-1:0] size_reg;
    logic [rasum_pkg::FIELD_W-1:0] size_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    rasum_pkg::rsp_t               rsp_reg;
    rasum_pkg::rsp_t               dp_result;
    rasum_pkg::dp_status_t         status;
    rasum_pkg::ucode_t             ctrl;
    logic                          seq_ready;
    logic                          req_accept;
    logic                          rsp_free;
    logic                          rsp_load;
    logic                          cfg_write;

    rasum_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .req_accept (req_accept),
        .rsp_free   (rsp_free),
        .ctrl       (ctrl),
        .ready      (seq_ready)
    );

    rasum_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .req_accept (req_accept),
        .req        (req),
        .size       (size_reg),
        .status     (status),
        .result     (dp_result)
    );

    assign req_ready  = seq_ready;
    assign req_accept = req_valid && seq_ready;
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_load   = ctrl.emit && rsp_free;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;

    always_comb
    begin
        size_next = size_reg;
        prdata    = '0;
        case (paddr[2])
            rasum_pkg::REG_SIZE_IN_USE:
            begin
                prdata = rasum_pkg::PDATA_W'(size_reg);
                if (cfg_write)
                begin
                    size_next = pwdata[rasum_pkg::FIELD_W-1:0];
                end
            end
            default: ;
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= rasum_pkg::SIZE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= dp_result;
        end
    end

    `RASUM_ASSERT_IMP(a_no_accept_while_clearing, status.clearing, !req_ready)
    `RASUM_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `RASUM_ASSERT_IMP(a_error_total_zero, rsp_valid && rsp.range_error, rsp.range_total == '0)
    `RASUM_ASSERT_NXT(a_emit_lands, ctrl.emit && rsp_free, rsp_valid)

endmodule
